@@ hdl/configurable_crc_engine_defines.svh @@
// Assertion macros shared by the CRC engine RTL.
`ifndef CONFIGURABLE_CRC_ENGINE_DEFINES_SVH
`define CONFIGURABLE_CRC_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CCE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/cce_pkg.sv @@
// Types and constants of the configurable CRC engine.
package cce_pkg;

	localparam int CRC_W   = 16;
	localparam int BYTE_W  = 8;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [1:0] {
		MODE_CRC8_MSB   = 2'd0,
		MODE_CRC8_LSB   = 2'd1,
		MODE_CRC16_REFL = 2'd2,
		MODE_CRC16_MSB  = 2'd3
	} crc_mode_t;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_CRC_MODE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POLYNOMIAL    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SEED_VALUE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT_SEED   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT_RESULT = 3'd4;

	localparam crc_mode_t        RST_CRC_MODE   = MODE_CRC16_REFL;
	localparam logic [CRC_W-1:0] RST_POLYNOMIAL = 16'ha001;
	localparam logic [CRC_W-1:0] RST_SEED_VALUE = 16'hffff;

	localparam logic [CRC_W-1:0] ALL_ONES = {CRC_W{1'b1}};

	typedef struct packed {
		crc_mode_t        mode;
		logic [CRC_W-1:0] polynomial;
		logic [CRC_W-1:0] seed_value;
		logic             invert_seed;
		logic             invert_result;
	} cce_cfg_t;

	// 16-bit modes carry the seed/result inversions and the full register
	function automatic logic is_wide(input crc_mode_t mode);
		is_wide = (mode == MODE_CRC16_REFL) || (mode == MODE_CRC16_MSB);
	endfunction

endpackage

@@ hdl/cce_cfg_regs.sv @@
// Configuration register file of the CRC engine.
module cce_cfg_regs
	import cce_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	output cce_cfg_t             cfg
);

	cce_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode          <= RST_CRC_MODE;
			cfg_q.polynomial    <= RST_POLYNOMIAL;
			cfg_q.seed_value    <= RST_SEED_VALUE;
			cfg_q.invert_seed   <= 1'b0;
			cfg_q.invert_result <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CRC_MODE:      cfg_q.mode          <= crc_mode_t'(cfg_wdata[1:0]);
				REG_POLYNOMIAL:    cfg_q.polynomial    <= cfg_wdata[CRC_W-1:0];
				REG_SEED_VALUE:    cfg_q.seed_value    <= cfg_wdata[CRC_W-1:0];
				REG_INVERT_SEED:   cfg_q.invert_seed   <= cfg_wdata[0];
				REG_INVERT_RESULT: cfg_q.invert_result <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hdl/cce_fold.sv @@
// Byte fold: seed selection, eight shift/XOR bit steps for all modes, and result inversion.
module cce_fold
	import cce_pkg::*;
(
	input  cce_cfg_t          cfg,
	input  logic [CRC_W-1:0]  acc_in,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              first_byte,
	output logic [CRC_W-1:0]  crc_next,
	output logic [CRC_W-1:0]  crc_out
);

	logic             wide;
	logic [CRC_W-1:0] acc;

	assign wide = is_wide(cfg.mode);

	always_comb begin
		acc = acc_in;
		if (first_byte) begin
			acc = cfg.seed_value ^ ((wide && cfg.invert_seed) ? ALL_ONES : '0);
		end
		if (!wide) begin
			acc[CRC_W-1:BYTE_W] = '0;
		end
	end

	always_comb begin
		logic [BYTE_W-1:0] c8;
		logic [BYTE_W-1:0] g8;
		logic [CRC_W-1:0]  c16;
		g8  = cfg.polynomial[BYTE_W-1:0];
		c8  = acc[BYTE_W-1:0] ^ data_byte;
		c16 = '0;
		crc_next = '0;
		case (cfg.mode)
			MODE_CRC8_MSB: begin
				for (int k = 0; k < BYTE_W; k++) begin
					c8 = c8[BYTE_W-1] ? ({c8[BYTE_W-2:0], 1'b0} ^ g8) : {c8[BYTE_W-2:0], 1'b0};
				end
				crc_next = {{(CRC_W-BYTE_W){1'b0}}, c8};
			end
			MODE_CRC8_LSB: begin
				// data bits line up with the register as both shift right
				for (int k = 0; k < BYTE_W; k++) begin
					c8 = c8[0] ? ({1'b0, c8[BYTE_W-1:1]} ^ g8) : {1'b0, c8[BYTE_W-1:1]};
				end
				crc_next = {{(CRC_W-BYTE_W){1'b0}}, c8};
			end
			MODE_CRC16_REFL: begin
				c16 = acc ^ {{(CRC_W-BYTE_W){1'b0}}, data_byte};
				for (int k = 0; k < BYTE_W; k++) begin
					c16 = c16[0] ? ({1'b0, c16[CRC_W-1:1]} ^ cfg.polynomial)
					             : {1'b0, c16[CRC_W-1:1]};
				end
				crc_next = c16;
			end
			MODE_CRC16_MSB: begin
				c16 = acc ^ {data_byte, {(CRC_W-BYTE_W){1'b0}}};
				for (int k = 0; k < BYTE_W; k++) begin
					c16 = c16[CRC_W-1] ? ({c16[CRC_W-2:0], 1'b0} ^ cfg.polynomial)
					                   : {c16[CRC_W-2:0], 1'b0};
				end
				crc_next = c16;
			end
			default: crc_next = '0;
		endcase
	end

	assign crc_out = crc_next ^ ((wide && cfg.invert_result) ? ALL_ONES : '0);

endmodule

@@ hdl/configurable_crc_engine.sv @@
// Top level of the configurable CRC engine.
//
//  channel  dir  handshake           payload
//  s_*      in   s_tvalid/s_tready   tdata: data_byte, tuser: first_byte, tlast: last_byte
//  m_*      out  m_tvalid/m_tready   tdata: crc_result
//  cfg_*    in   cfg_we              cfg_index, cfg_wdata
//
// One byte per cycle while no last byte waits on m_tready; a taken byte is registered
// in the input stage and folds there, and a last byte's CRC shows on m_* the cycle after.
// The limit is the running CRC register, updated once per byte by the fold unit.
// A last byte waits in the input stage while the output register holds an
// untaken result, and the next request waits behind it; a byte that is not
// last folds without waiting on m_tready.
// Reset clears the running CRC to zero and loads the configuration defaults.
module configurable_crc_engine
	import cce_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // [7:0] data_byte
	input  logic [0:0]           s_tuser,   // [0] first_byte
	input  logic                 s_tlast,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [15:0]          m_tdata,   // [15:0] crc_result
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	`include "configurable_crc_engine_defines.svh"

	cce_cfg_t cfg;

	logic              valid_s1;
	logic [BYTE_W-1:0] data_s1;
	logic              first_s1;
	logic              last_s1;
	logic [CRC_W-1:0]  running_crc_q;
	logic              m_tvalid_q;
	logic [CRC_W-1:0]  m_tdata_q;
	logic [CRC_W-1:0]  crc_next;
	logic [CRC_W-1:0]  crc_out;
	logic              out_free;
	logic              fire_s1;

	cce_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	cce_fold u_fold (
		.cfg        (cfg),
		.acc_in     (running_crc_q),
		.data_byte  (data_s1),
		.first_byte (first_s1),
		.crc_next   (crc_next),
		.crc_out    (crc_out)
	);

	assign out_free = !m_tvalid_q || m_tready;
	assign fire_s1  = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1  <= s_tdata;
			first_s1 <= s_tuser[0];
			last_s1  <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_crc_q <= '0;
		end else if (fire_s1) begin
			running_crc_q <= crc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (fire_s1 && last_s1) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && last_s1) begin
			m_tdata_q <= crc_out;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`CCE_ASSERT_NEXT(a_result_loaded, clk, arst_n, fire_s1 && last_s1,
		m_tvalid && (m_tdata == $past(crc_out)), "finished CRC not presented")
	`CCE_ASSERT_SAME(a_last_waits, clk, arst_n, valid_s1 && last_s1 && !out_free,
		!s_tready && !fire_s1, "last byte folded over an untaken result")
	`CCE_ASSERT_NEXT(a_crc_hold, clk, arst_n, !fire_s1,
		$stable(running_crc_q), "running CRC changed without a byte")
	`CCE_ASSERT_SAME(a_crc8_upper, clk, arst_n, fire_s1 && !is_wide(cfg.mode),
		crc_next[CRC_W-1:BYTE_W] == '0, "upper CRC bits set in 8-bit mode")

endmodule

@@ bench/configurable_crc_engine_tb.sv @@
`timescale 1ns / 1ps
// Testbench for the CRC engine: directed and random byte streams, checked against a local CRC model.
module configurable_crc_engine_tb;
	import cce_pkg::*;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [7:0]           s_tdata;   // [7:0] data_byte
	logic [0:0]           s_tuser;   // [0] first_byte
	logic                 s_tlast;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [15:0]          m_tdata;   // [15:0] crc_result
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	configurable_crc_engine DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Local copy of the engine's configuration and running CRC
	cce_cfg_t    crc_cfg;
	logic [15:0] running_crc;
	logic [15:0] pending_crcs [$];
	logic [15:0] want_crc;
	int          mismatches = 0;
	bit          stall_en = 1'b1;

	function automatic logic [15:0] fold_crc(logic [15:0] acc, logic [7:0] data,
			crc_mode_t mode, logic [15:0] gen);
		logic [15:0] c;
		logic [7:0]  d;
		logic        mix;
		d = data;
		case (mode)
			MODE_CRC8_MSB: begin
				c = {8'h00, acc[7:0] ^ data};
				for (int k = 0; k < 8; k++)
					c[7:0] = c[7] ? ({c[6:0], 1'b0} ^ gen[7:0]) : {c[6:0], 1'b0};
			end
			MODE_CRC8_LSB: begin
				c = {8'h00, acc[7:0]};
				for (int k = 0; k < 8; k++) begin
					mix = c[0] ^ d[0];
					c[7:0] = {1'b0, c[7:1]} ^ (mix ? gen[7:0] : 8'h00);
					d = {1'b0, d[7:1]};
				end
			end
			MODE_CRC16_REFL: begin
				c = acc ^ {8'h00, data};
				for (int k = 0; k < 8; k++)
					c = c[0] ? ({1'b0, c[15:1]} ^ gen) : {1'b0, c[15:1]};
			end
			default: begin
				c = acc ^ {data, 8'h00};
				for (int k = 0; k < 8; k++)
					c = c[15] ? ({c[14:0], 1'b0} ^ gen) : {c[14:0], 1'b0};
			end
		endcase
		return c;
	endfunction

	// Fold one accepted request into the model; a last byte queues its CRC
	task automatic predict_crc(logic [7:0] data, bit first, bit last);
		logic [15:0] acc;
		logic        wide;
		wide = (crc_cfg.mode == MODE_CRC16_REFL) || (crc_cfg.mode == MODE_CRC16_MSB);
		acc = running_crc;
		if (first)
			acc = crc_cfg.seed_value ^ ((wide && crc_cfg.invert_seed) ? ALL_ONES : 16'h0000);
		if (!wide)
			acc = {8'h00, acc[7:0]};
		running_crc = fold_crc(acc, data, crc_cfg.mode, crc_cfg.polynomial);
		if (last)
			pending_crcs.push_back(running_crc ^
				((wide && crc_cfg.invert_result) ? ALL_ONES : 16'h0000));
	endtask

	task automatic send_byte(logic [7:0] data, bit first, bit last);
		if (stall_en && $urandom_range(99) < 15) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tuser  <= first;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_crc(data, first, last);
	endtask

	// Drain results, then give the fold stage time to settle on trailing bytes
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_crcs.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cfg(crc_mode_t mode, logic [15:0] poly, logic [15:0] seed,
			bit inv_seed, bit inv_result);
		logic [15:0] vals [0:4];
		wait_idle();
		vals[REG_CRC_MODE]      = {14'h0000, mode};
		vals[REG_POLYNOMIAL]    = poly;
		vals[REG_SEED_VALUE]    = seed;
		vals[REG_INVERT_SEED]   = {15'h0000, inv_seed};
		vals[REG_INVERT_RESULT] = {15'h0000, inv_result};
		for (int r = REG_CRC_MODE; r <= REG_INVERT_RESULT; r++) begin
			cfg_we    <= 1'b1;
			cfg_index <= r[CFG_IDX_W-1:0];
			cfg_wdata <= vals[r];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		crc_cfg.mode          = mode;
		crc_cfg.polynomial    = poly;
		crc_cfg.seed_value    = seed;
		crc_cfg.invert_seed   = inv_seed;
		crc_cfg.invert_result = inv_result;
	endtask

	task automatic note_mismatch(string what, logic [15:0] want, logic [15:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: expected %04h, got %04h", $realtime, what, want, got);
	endtask

	// Result side: compare each taken CRC, then pick the next ready level
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_crcs.size() == 0) begin
				note_mismatch("unexpected crc_result", 16'h0000, m_tdata);
			end else begin
				want_crc = pending_crcs.pop_front();
				if (m_tdata !== want_crc)
					note_mismatch("crc_result", want_crc, m_tdata);
			end
		end
		m_tready <= !stall_en || ($urandom_range(99) >= 15);
	end

	// Defaults still loaded; bytes before any first byte start from zero
	task automatic test_after_reset();
		send_byte(8'hff, 1'b0, 1'b1);
		send_byte(8'h00, 1'b1, 1'b1);
		send_byte(8'h5a, 1'b0, 1'b0);
		send_byte(8'ha5, 1'b0, 1'b1);
	endtask

	task automatic test_each_mode();
		write_cfg(MODE_CRC8_MSB, 16'h0007, 16'h0000, 1'b1, 1'b1);
		send_byte(8'h00, 1'b1, 1'b0);
		send_byte(8'hff, 1'b0, 1'b1);
		write_cfg(MODE_CRC8_LSB, 16'h008c, 16'hffff, 1'b1, 1'b1);
		send_byte(8'h00, 1'b1, 1'b0);
		send_byte(8'hff, 1'b0, 1'b1);
		write_cfg(MODE_CRC16_REFL, 16'h8408, 16'hffff, 1'b1, 1'b1);
		send_byte(8'h00, 1'b1, 1'b0);
		send_byte(8'hff, 1'b0, 1'b1);
		write_cfg(MODE_CRC16_MSB, 16'h1021, 16'h0000, 1'b1, 1'b0);
		send_byte(8'h00, 1'b1, 1'b0);
		send_byte(8'hff, 1'b0, 1'b1);
		// Polynomial and seed at their extremes
		write_cfg(MODE_CRC16_MSB, 16'hffff, 16'h0000, 1'b0, 1'b1);
		send_byte(8'hff, 1'b1, 1'b1);
		write_cfg(MODE_CRC16_REFL, 16'h0000, 16'hffff, 1'b0, 1'b0);
		send_byte(8'hff, 1'b1, 1'b1);
	endtask

	// Switch from 16-bit to 8-bit while a message is still open, then back with no new first byte
	task automatic test_mid_message_switch();
		write_cfg(MODE_CRC16_MSB, 16'h1021, 16'hffff, 1'b0, 1'b0);
		send_byte(8'ha5, 1'b1, 1'b0);
		write_cfg(MODE_CRC8_MSB, 16'h0031, 16'h0000, 1'b0, 1'b0);
		send_byte(8'h5a, 1'b0, 1'b1);
		write_cfg(MODE_CRC16_REFL, 16'ha001, 16'h1234, 1'b1, 1'b1);
		send_byte(8'h3c, 1'b0, 1'b1);
	endtask

	function automatic logic [15:0] pick_word();
		case ($urandom_range(5))
			0: return 16'h0000;
			1: return 16'hffff;
			2: return 16'h8408;
			3: return 16'ha001;
			4: return 16'h1021;
			default: return 16'($urandom());
		endcase
	endfunction

	task automatic test_random_traffic(int phases, int per_phase);
		int  sent;
		int  len;
		bit  first_b;
		bit  last_b;
		for (int p = 0; p < phases; p++) begin
			// one phase runs with neither side stalling
			stall_en = (p != phases / 2);
			write_cfg(crc_mode_t'($urandom_range(3)), pick_word(), pick_word(),
				1'($urandom_range(1)), 1'($urandom_range(1)));
			sent = 0;
			while (sent < per_phase) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
				for (int i = 0; i < len; i++) begin
					first_b = (i == 0) && ($urandom_range(9) != 0);
					last_b  = (i == len - 1);
					// occasional broken framing
					if ($urandom_range(19) == 0) begin
						first_b = 1'($urandom_range(1));
						last_b  = 1'($urandom_range(1));
					end
					send_byte(8'($urandom_range(255)), first_b, last_b);
					sent++;
				end
			end
			// sometimes leave a message open across the next configuration
			if ($urandom_range(3) == 0)
				send_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0);
		end
		stall_en = 1'b1;
	endtask

	initial begin
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= 8'h00;
		s_tuser   <= 1'b0;
		s_tlast   <= 1'b0;
		m_tready  <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_CRC_MODE;
		cfg_wdata <= 16'h0000;
		crc_cfg.mode          = RST_CRC_MODE;
		crc_cfg.polynomial    = RST_POLYNOMIAL;
		crc_cfg.seed_value    = RST_SEED_VALUE;
		crc_cfg.invert_seed   = 1'b0;
		crc_cfg.invert_result = 1'b0;
		running_crc = 16'h0000;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_after_reset();
		test_each_mode();
		test_mid_message_switch();
		test_random_traffic(40, 40);

		s_tvalid <= 1'b0;
		while (pending_crcs.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending_crcs.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/cce_pkg.sv
hdl/cce_cfg_regs.sv
hdl/cce_fold.sv
hdl/configurable_crc_engine.sv
bench/configurable_crc_engine_tb.sv
